// ===== hdl/lavm_pkg.sv =====
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared constants and rounding helpers for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lavm_pkg;

    // unit vectors are Q1.30
    localparam int UNIT_BITS = 30;
    localparam logic signed [63:0] UNIT_ONE = 64'sd1 <<< UNIT_BITS;
    localparam logic signed [63:0] I32_MAX  = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN  = -64'sd2147483648;

    typedef logic signed [63:0] t_wide;
    typedef logic [2:0][31:0]   t_vec3;

    // v / 2^30, magnitude rounded half away from zero
    function automatic t_wide rnd_unit(input t_wide v);
        logic [63:0] m;
        m = v[63] ? (64'd0 - v) : v;
        m = (m + (64'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
        return v[63] ? t_wide'(64'd0 - m) : t_wide'(m);
    endfunction

    // rounded value clamped to +-1.0 in Q1.30
    function automatic logic [31:0] clamp_unit(input t_wide v);
        t_wide r;
        r = rnd_unit(v);
        if (r > UNIT_ONE)
            r = UNIT_ONE;
        else if (r < -UNIT_ONE)
            r = -UNIT_ONE;
        return r[31:0];
    endfunction

    // negated, rounded translation saturated to 32 bits
    function automatic logic [31:0] neg_sat(input t_wide v);
        t_wide t;
        t = -rnd_unit(v);
        if (t > I32_MAX)
            t = I32_MAX;
        else if (t < I32_MIN)
            t = I32_MIN;
        return t[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/look_at_view_matrix.sv =====
// Throughput: one item per cycle unless the output stalls; every stage is pipelined,
// including the two 32-stage square roots and the two 31-stage three-lane dividers.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Look-at view basis: forward, right and true up unit vectors in Q1.30 and
// the three negated, saturated translations.
// ----------------------------------------------------------------------------
`default_nettype none

module look_at_view_matrix (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_hint_x, up_hint_y, up_hint_z
    input  wire [287:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // right_x/y/z, true_up_x/y/z, forward_x/y/z, shift_right, shift_up, shift_forward
    output logic [383:0] m_axis_tdata
);
    import lavm_pkg::*;

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // stage 0: eye minus target
    logic             r_v0;
    logic [2:0][32:0] r_d0;
    t_vec3            r_eye0;
    t_vec3            r_hint0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= s_axis_tvalid;
        end
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_d0[i]    <= {s_axis_tdata[i*32 + 31], s_axis_tdata[i*32 +: 32]}
                            - {s_axis_tdata[96 + i*32 + 31], s_axis_tdata[96 + i*32 +: 32]};
                r_eye0[i]  <= s_axis_tdata[i*32 +: 32];
                r_hint0[i] <= s_axis_tdata[192 + i*32 +: 32];
            end
        end
    end

    // forward = unit(eye - target)
    logic         f_valid;
    t_vec3        f_vec;
    logic [191:0] f_side;

    lavm_unitize #(.IN_W(33), .SIDE_W(192)) u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v0),
        .i_c     (r_d0),
        .i_side  ({r_hint0, r_eye0}),
        .o_valid (f_valid),
        .o_u     (f_vec),
        .o_side  (f_side)
    );

    // stage 1: up_hint x forward products
    logic             r_v1;
    t_wide            r_hp1 [0:5];
    t_vec3            r_eye1;
    t_vec3            r_f1;
    t_vec3            n_hint;

    assign n_hint = f_side[191:96];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= f_valid;
        end
        if (en) begin
            r_hp1[0] <= $signed(n_hint[1]) * $signed(f_vec[2]);
            r_hp1[1] <= $signed(n_hint[2]) * $signed(f_vec[1]);
            r_hp1[2] <= $signed(n_hint[2]) * $signed(f_vec[0]);
            r_hp1[3] <= $signed(n_hint[0]) * $signed(f_vec[2]);
            r_hp1[4] <= $signed(n_hint[0]) * $signed(f_vec[1]);
            r_hp1[5] <= $signed(n_hint[1]) * $signed(f_vec[0]);
            r_eye1   <= f_side[95:0];
            r_f1     <= f_vec;
        end
    end

    // stage 2: cross product differences
    logic             r_v2;
    logic [2:0][63:0] r_rc2;
    t_vec3            r_eye2;
    t_vec3            r_f2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
        if (en) begin
            r_rc2[0] <= r_hp1[0] - r_hp1[1];
            r_rc2[1] <= r_hp1[2] - r_hp1[3];
            r_rc2[2] <= r_hp1[4] - r_hp1[5];
            r_eye2   <= r_eye1;
            r_f2     <= r_f1;
        end
    end

    // right = unit(up_hint x forward)
    logic         r_valid;
    t_vec3        r_vec;
    logic [191:0] r_side;

    lavm_unitize #(.IN_W(64), .SIDE_W(192)) u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v2),
        .i_c     (r_rc2),
        .i_side  ({r_f2, r_eye2}),
        .o_valid (r_valid),
        .o_u     (r_vec),
        .o_side  (r_side)
    );

    // stage 3: forward x right products and translation products
    logic  r_v3;
    t_wide r_up3 [0:5];
    t_wide r_er3 [0:2];
    t_wide r_ef3 [0:2];
    t_vec3 r_eye3;
    t_vec3 r_f3;
    t_vec3 r_r3;
    t_vec3 n_f;
    t_vec3 n_eye;

    assign n_f   = r_side[191:96];
    assign n_eye = r_side[95:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_valid;
        end
        if (en) begin
            r_up3[0] <= $signed(n_f[1]) * $signed(r_vec[2]);
            r_up3[1] <= $signed(n_f[2]) * $signed(r_vec[1]);
            r_up3[2] <= $signed(n_f[2]) * $signed(r_vec[0]);
            r_up3[3] <= $signed(n_f[0]) * $signed(r_vec[2]);
            r_up3[4] <= $signed(n_f[0]) * $signed(r_vec[1]);
            r_up3[5] <= $signed(n_f[1]) * $signed(r_vec[0]);
            for (int i = 0; i < 3; i++) begin
                r_er3[i] <= $signed(r_vec[i]) * $signed(n_eye[i]);
                r_ef3[i] <= $signed(n_f[i]) * $signed(n_eye[i]);
            end
            r_eye3 <= n_eye;
            r_f3   <= n_f;
            r_r3   <= r_vec;
        end
    end

    // stage 4: differences and dot sums
    logic  r_v4;
    t_wide r_ur4 [0:2];
    t_wide r_sr4;
    t_wide r_sf4;
    t_vec3 r_eye4;
    t_vec3 r_f4;
    t_vec3 r_r4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
        if (en) begin
            r_ur4[0] <= r_up3[0] - r_up3[1];
            r_ur4[1] <= r_up3[2] - r_up3[3];
            r_ur4[2] <= r_up3[4] - r_up3[5];
            r_sr4    <= r_er3[0] + r_er3[1] + r_er3[2];
            r_sf4    <= r_ef3[0] + r_ef3[1] + r_ef3[2];
            r_eye4   <= r_eye3;
            r_f4     <= r_f3;
            r_r4     <= r_r3;
        end
    end

    // stage 5: round true up, finish right and forward translations
    logic        r_v5;
    t_vec3       r_u5;
    logic [31:0] r_tr5;
    logic [31:0] r_tf5;
    t_vec3       r_eye5;
    t_vec3       r_f5;
    t_vec3       r_r5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5 <= r_v4;
        end
        if (en) begin
            for (int i = 0; i < 3; i++)
                r_u5[i] <= clamp_unit(r_ur4[i]);
            r_tr5  <= neg_sat(r_sr4);
            r_tf5  <= neg_sat(r_sf4);
            r_eye5 <= r_eye4;
            r_f5   <= r_f4;
            r_r5   <= r_r4;
        end
    end

    // stage 6: true up translation products
    logic        r_v6;
    t_wide       r_eu6 [0:2];
    t_vec3       r_u6;
    logic [31:0] r_tr6;
    logic [31:0] r_tf6;
    t_vec3       r_f6;
    t_vec3       r_r6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v6 <= r_v5;
        end
        if (en) begin
            for (int i = 0; i < 3; i++)
                r_eu6[i] <= $signed(r_u5[i]) * $signed(r_eye5[i]);
            r_u6  <= r_u5;
            r_tr6 <= r_tr5;
            r_tf6 <= r_tf5;
            r_f6  <= r_f5;
            r_r6  <= r_r5;
        end
    end

    // stage 7: true up dot sum
    logic        r_v7;
    t_wide       r_su7;
    t_vec3       r_u7;
    logic [31:0] r_tr7;
    logic [31:0] r_tf7;
    t_vec3       r_f7;
    t_vec3       r_r7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else if (en) begin
            r_v7 <= r_v6;
        end
        if (en) begin
            r_su7 <= r_eu6[0] + r_eu6[1] + r_eu6[2];
            r_u7  <= r_u6;
            r_tr7 <= r_tr6;
            r_tf7 <= r_tf6;
            r_f7  <= r_f6;
            r_r7  <= r_r6;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (en) begin
            m_axis_tvalid <= r_v7;
        end
        if (en) begin
            m_axis_tdata <= {r_tf7, neg_sat(r_su7), r_tr7, r_f7, r_u7, r_r7};
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lavm_unitize.sv =====
// ----------------------------------------------------------------------------
// lavm_unitize
// Pipelined vector normalizer: scales a 3-vector to unit length in Q1.30.
// Stages: magnitude, msb scan (two), shift, square, sum, 32 root stages,
// divide setup, 31 divide stages with the sign applied in the last one.
// One item a cycle while i_en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lavm_unitize #(
    parameter int IN_W   = 33,
    parameter int SIDE_W = 192
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_valid,
    input  wire [2:0][IN_W-1:0]     i_c,
    input  wire [SIDE_W-1:0]        i_side,
    output logic                    o_valid,
    output logic [2:0][31:0]        o_u,
    output logic [SIDE_W-1:0]       o_side
);
    import lavm_pkg::*;

    localparam int NG = (IN_W + 7) / 8;
    localparam int PW = $clog2(NG * 8);
    localparam int CW = SIDE_W + 94;   // side, neg, zero, three 30-bit mags
    localparam int DW = SIDE_W + 4;    // side, neg, zero

    // stage 1: magnitudes
    logic                   r_v1;
    logic [2:0][IN_W-1:0]   r_m1;
    logic [2:0]             r_neg1;
    logic [IN_W-1:0]        r_or1;
    logic [SIDE_W-1:0]      r_side1;
    logic [2:0][IN_W-1:0]   n_m1;
    logic [2:0]             n_neg1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_neg1[i] = i_c[i][IN_W-1];
            n_m1[i]   = n_neg1[i] ? (IN_W'(0) - i_c[i]) : i_c[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_m1    <= n_m1;
            r_neg1  <= n_neg1;
            r_or1   <= n_m1[0] | n_m1[1] | n_m1[2];
            r_side1 <= i_side;
        end
    end

    // stage 2: per-byte msb scan
    logic                   r_v2;
    logic [2:0][IN_W-1:0]   r_m2;
    logic [2:0]             r_neg2;
    logic [SIDE_W-1:0]      r_side2;
    logic [NG-1:0]          r_nz2;
    logic [NG-1:0][2:0]     r_pos2;
    logic [NG*8-1:0]        n_orp;
    logic [NG-1:0]          n_nz2;
    logic [NG-1:0][2:0]     n_pos2;

    always_comb begin
        n_orp = (NG*8)'(r_or1);
        for (int g = 0; g < NG; g++) begin
            n_nz2[g]  = |n_orp[g*8 +: 8];
            n_pos2[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (n_orp[g*8 + b])
                    n_pos2[g] = 3'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_m2    <= r_m1;
            r_neg2  <= r_neg1;
            r_side2 <= r_side1;
            r_nz2   <= n_nz2;
            r_pos2  <= n_pos2;
        end
    end

    // stage 3: msb position of the largest magnitude
    logic                   r_v3;
    logic [2:0][IN_W-1:0]   r_m3;
    logic [2:0]             r_neg3;
    logic [SIDE_W-1:0]      r_side3;
    logic [PW-1:0]          r_p3;
    logic                   r_zero3;
    logic [PW-1:0]          n_p3;
    logic                   n_zero3;

    always_comb begin
        n_p3    = '0;
        n_zero3 = 1'b1;
        for (int g = 0; g < NG; g++) begin
            if (r_nz2[g]) begin
                n_p3    = PW'(g * 8) + PW'(r_pos2[g]);
                n_zero3 = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
        if (i_en) begin
            r_m3    <= r_m2;
            r_neg3  <= r_neg2;
            r_side3 <= r_side2;
            r_p3    <= n_p3;
            r_zero3 <= n_zero3;
        end
    end

    // stage 4: shift so that the largest magnitude lies in [2^29, 2^30)
    logic                   r_v4;
    logic [CW-1:0]          r_c4;
    logic [2:0][29:0]       n_n4;
    logic [PW-1:0]          n_rsh;
    logic [PW-1:0]          n_lsh;
    logic [IN_W-1:0]        n_tr;
    logic [IN_W+29:0]       n_tl;

    always_comb begin
        n_rsh = r_p3 - PW'(29);
        n_lsh = PW'(29) - r_p3;
        n_tr  = '0;
        n_tl  = '0;
        for (int i = 0; i < 3; i++) begin
            n_tr = r_m3[i] >> n_rsh;
            n_tl = {30'd0, r_m3[i]} << n_lsh;
            n_n4[i] = (r_p3 >= PW'(29)) ? n_tr[29:0] : n_tl[29:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
        if (i_en) begin
            r_c4 <= {r_side3, r_neg3, r_zero3, n_n4[2], n_n4[1], n_n4[0]};
        end
    end

    // stage 5: squares
    logic                   r_v5;
    logic [CW-1:0]          r_c5;
    logic [2:0][59:0]       r_sq5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v5 <= r_v4;
        end
        if (i_en) begin
            r_c5 <= r_c4;
            for (int i = 0; i < 3; i++)
                r_sq5[i] <= 60'(r_c4[i*30 +: 30]) * 60'(r_c4[i*30 +: 30]);
        end
    end

    // stage 6 (root stage 0): sum of squares
    logic [63:0]            r_sn [0:32];
    logic [63:0]            r_sr [0:32];
    logic [CW-1:0]          r_sc [0:32];
    logic                   r_sv [0:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (i_en) begin
            r_sv[0] <= r_v5;
        end
        if (i_en) begin
            r_sn[0] <= 64'(r_sq5[0]) + 64'(r_sq5[1]) + 64'(r_sq5[2]);
            r_sr[0] <= '0;
            r_sc[0] <= r_c5;
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < 32; k++) begin : g_root
        localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
        logic [63:0] n_try;
        logic [63:0] n_sn;
        logic [63:0] n_sr;

        always_comb begin
            n_try = r_sr[k] + BITV;
            if (r_sn[k] >= n_try) begin
                n_sn = r_sn[k] - n_try;
                n_sr = (r_sr[k] >> 1) + BITV;
            end else begin
                n_sn = r_sn[k];
                n_sr = r_sr[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (i_en) begin
                r_sv[k+1] <= r_sv[k];
            end
            if (i_en) begin
                r_sn[k+1] <= n_sn;
                r_sr[k+1] <= n_sr;
                r_sc[k+1] <= r_sc[k];
            end
        end
    end

    // divide setup: numerator = mag * 2^30 + len / 2
    logic [2:0][60:0]       r_rem [0:30];
    logic [2:0][30:0]       r_q   [0:30];
    logic [30:0]            r_len [0:30];
    logic [DW-1:0]          r_dc  [0:30];
    logic                   r_dv  [0:30];
    logic [30:0]            n_len;

    assign n_len = r_sr[32][30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (i_en) begin
            r_dv[0] <= r_sv[32];
        end
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= {1'b0, r_sc[32][i*30 +: 30], 30'd0} + 61'(n_len >> 1);
                r_q[0][i]   <= '0;
            end
            r_len[0] <= n_len;
            r_dc[0]  <= r_sc[32][CW-1:90];
        end
    end

    // restoring division, one quotient bit per stage, three lanes
    for (genvar j = 0; j < 31; j++) begin : g_div
        localparam int SH = 30 - j;
        logic [60:0]       n_dd;
        logic [2:0][60:0]  n_rem;
        logic [2:0][30:0]  n_q;

        always_comb begin
            n_dd = {30'd0, r_len[j]} << SH;
            for (int i = 0; i < 3; i++) begin
                if (r_rem[j][i] >= n_dd) begin
                    n_rem[i] = r_rem[j][i] - n_dd;
                    n_q[i]   = r_q[j][i] | (31'd1 << SH);
                end else begin
                    n_rem[i] = r_rem[j][i];
                    n_q[i]   = r_q[j][i];
                end
            end
        end

        if (j < 30) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[j+1] <= 1'b0;
                end else if (i_en) begin
                    r_dv[j+1] <= r_dv[j];
                end
                if (i_en) begin
                    r_rem[j+1] <= n_rem;
                    r_q[j+1]   <= n_q;
                    r_len[j+1] <= r_len[j];
                    r_dc[j+1]  <= r_dc[j];
                end
            end
        end else begin : g_last
            // last divide stage also applies the sign and drives the outputs directly
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    o_valid <= 1'b0;
                end else if (i_en) begin
                    o_valid <= r_dv[30];
                end
                if (i_en) begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_dc[30][0])
                            o_u[i] <= '0;
                        else if (r_dc[30][1 + i])
                            o_u[i] <= 32'd0 - {1'b0, n_q[i]};
                        else
                            o_u[i] <= {1'b0, n_q[i]};
                    end
                    o_side <= r_dc[30][DW-1:4];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lavm_checker.sv =====
// ----------------------------------------------------------------------------
// lavm_checker
// Port-level checks for look_at_view_matrix, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lavm_port_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [383:0] m_axis_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // input stalls exactly when a result is stuck
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output blocked");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input held off with free output");

    // reset empties the output
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // forward x stays within unit range
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[223:192]) <= 32'sd1073741824
                       && $signed(m_axis_tdata[223:192]) >= -32'sd1073741824)
        else $error("forward x beyond unit range");

endmodule

bind look_at_view_matrix lavm_port_checker u_lavm_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
